// ===== rtl/refe_pkg.sv =====
// Shared types, codes and flag-word encoding for the register entry flag encoder.
package refe_pkg;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_ENTRY = 2'd1,
        OP_EMPTY = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT,
        ST_PAD
    } state_t;

    typedef struct packed {
        logic latch;
        logic write_mask;
        logic restart;
        logic search;
        logic emit;
        logic pad;
    } refe_cmd_t;

    typedef struct packed {
        opcode_t in_op;
        logic    in_last;
        logic    slot_full;
        logic    search_done;
        logic    item_last;
        logic    tail_full;
        logic    out_free;
        logic    pad_end;
    } refe_status_t;

    localparam int          CNT_W       = 5;
    localparam int          IDX_W       = 5;
    localparam int          SLOT_W      = 4;
    localparam int          DATA_W      = 32;
    localparam logic [31:0] ENTRY_BASE  = 32'h1000_0000;
    localparam logic [31:0] MODE_BITS   = 32'h0300_0000;
    localparam logic [31:0] MODE_BASE   = 32'h0008_0000;
    localparam logic [31:0] M2_CLEAR    = 32'hffef_ffdf;
    localparam logic [31:0] NOHIT_SET   = 32'h0010_0020;
    localparam logic [31:0] NOHIT_CLEAR = 32'hffff_fbe0;
    localparam logic [31:0] BIT22       = 32'h0040_0000;
    localparam logic [31:0] LOW5_CLEAR  = 32'hffff_ffe0;
    localparam logic [31:0] BIT10_CLEAR = 32'hffff_fbff;
    localparam logic [31:0] BIT20       = 32'h0010_0000;
    localparam logic [31:0] BIT20_CLEAR = 32'hffef_ffff;
    localparam logic [31:0] BIT5        = 32'h0000_0020;
    localparam logic [31:0] BIT5_CLEAR  = 32'hffff_ffdf;
    localparam logic [31:0] BIT10       = 32'h0000_0400;
    localparam logic [31:0] LOW5        = 32'h0000_001f;

    function automatic logic [31:0] put_two(logic [31:0] v, logic [1:0] f, int pos);
        logic [31:0] m;
        begin
            m = 32'h3 << pos;
            return (v & ~m) | ({30'd0, f} << pos);
        end
    endfunction

    function automatic logic [31:0] encode_flags(logic [31:0] s, logic [31:0] m, logic hit);
        logic [1:0]  mode;
        logic [1:0]  hi2;
        logic [1:0]  b28;
        logic [31:0] mk;
        logic [31:0] flags;
        begin
            mode = s[21:20];
            hi2  = s[31:30];
            b28  = s[29:28];
            mk   = m & s;
            if (mode == 2'd0)
            begin
                flags = {31'd0, s[24] | ~hit} << 5;
                flags = put_two(flags, b28, 8);
            end
            else
            begin
                flags = ((s << 4) & MODE_BITS) + MODE_BASE;
                if (mode == 2'd2)
                begin
                    flags = flags & M2_CLEAR;
                    if (hit)
                        flags = flags | ((~mk >> 16) & BIT5);
                    else
                        flags = flags | BIT5;
                    flags = put_two(flags, hi2, 8);
                end
                else if (hit)
                begin
                    flags = flags & BIT5_CLEAR;
                    flags = flags | ((mk >> 15) & BIT5);
                    flags = flags ^ BIT5;
                    flags = flags & BIT20_CLEAR;
                    flags = flags | ((~mk >> 1) & BIT20);
                    flags = put_two(flags, hi2, 8);
                end
                else
                begin
                    flags = flags | NOHIT_SET;
                    flags = put_two(flags, b28, 8);
                end
                flags = put_two(flags, hi2, 21);
            end
            if (hit)
            begin
                flags = flags & LOW5_CLEAR;
                flags = flags | ((m >> 8) & LOW5);
                flags = flags & BIT10_CLEAR;
                flags = flags | (((s & BIT22) != 32'd0) ? BIT10 : ((s >> 14) & BIT10));
            end
            else
            begin
                flags = flags & NOHIT_CLEAR;
            end
            return flags;
        end
    endfunction

endpackage

// ===== rtl/refe_ram.sv =====
// Generic single-port-write, registered-read RAM.
module refe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/refe_ctrl.sv =====
// Controller state machine: item intake, mask search, result and padding sequencing.
module refe_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  refe_pkg::refe_status_t status,
    output refe_pkg::refe_cmd_t    cmd
);
    import refe_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch = 1'b1;
                    unique case (status.in_op)
                        OP_LOAD:
                        begin
                            cmd.write_mask = 1'b1;
                        end
                        OP_ENTRY:
                        begin
                            if (status.slot_full)
                                cmd.restart = status.in_last;
                            else
                                state_next = ST_SEARCH;
                        end
                        OP_EMPTY:
                        begin
                            cmd.restart = 1'b1;
                            state_next  = ST_PAD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                if (status.search_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.item_last && !status.tail_full)
                        state_next = ST_PAD;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (status.out_free)
                begin
                    cmd.pad = 1'b1;
                    if (status.pad_end)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/refe_dp.sv =====
// Datapath: mask table, first-match search, flag encoding, slot counting and output register.
module refe_dp #(
    parameter int MASK_DEPTH  = 16,
    parameter int OUT_ENTRIES = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [refe_pkg::CNT_W-1:0]      cfg_wdata,
    input  logic [1:0]                      s_tuser,
    input  logic [39:0]                     s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [71:0]                     m_tdata,
    output logic                            m_tlast,
    input  refe_pkg::refe_cmd_t             cmd,
    output refe_pkg::refe_status_t          status
);
    import refe_pkg::*;

    localparam int AW = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;
    localparam int SW = $clog2(MASK_DEPTH + 1);
    localparam int CW = $clog2(OUT_ENTRIES + 1);

    logic [SLOT_W-1:0] in_slot;
    logic [DATA_W-1:0] in_data;

    logic [CNT_W-1:0]  scan_len_reg;
    logic [DATA_W-1:0] data_reg;
    logic              last_reg;
    logic [SW-1:0]     scan_idx_reg;
    logic [SW-1:0]     scan_idx_next;
    logic              rd_pend_reg;
    logic              rd_pend_next;
    logic              hit_reg;
    logic [DATA_W-1:0] mask_reg;
    logic [CW-1:0]     slot_cnt_reg;
    logic [CW-1:0]     slot_cnt_next;
    logic [CW-1:0]     pad_idx_reg;
    logic [CW-1:0]     pad_idx_next;

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic [63:0]       out_word_reg;
    logic              out_last_reg;

    logic [SW-1:0]     limit;
    logic              ram_we;
    logic [DATA_W-1:0] ram_rdata;
    logic              issue;
    logic              match_now;
    logic              out_free;
    logic [CW-1:0]     out_idx;
    logic [31:0]       out_flags;

    assign in_slot = s_tdata[SLOT_W-1:0];
    assign in_data = s_tdata[SLOT_W +: DATA_W];

    assign limit = (32'(scan_len_reg) >= 32'(MASK_DEPTH)) ? SW'(MASK_DEPTH)
                                                           : SW'(scan_len_reg);

    assign ram_we = cmd.write_mask && (32'(in_slot) < 32'(MASK_DEPTH));

    refe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MASK_DEPTH),
        .AW    (AW)
    ) u_mask_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(in_slot)),
        .wdata (in_data),
        .raddr (scan_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign match_now = cmd.search && rd_pend_reg && (ram_rdata[7:0] == data_reg[7:0]);
    assign issue     = cmd.search && (scan_idx_reg < limit) && !hit_reg && !match_now;

    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        rd_pend_next  = 1'b0;
        if (cmd.latch)
        begin
            scan_idx_next = '0;
        end
        else if (issue)
        begin
            scan_idx_next = scan_idx_reg + SW'(1);
            rd_pend_next  = 1'b1;
        end
    end

    always_comb
    begin
        slot_cnt_next = slot_cnt_reg;
        pad_idx_next  = pad_idx_reg;
        if (cmd.restart)
        begin
            slot_cnt_next = '0;
            pad_idx_next  = '0;
        end
        else if (cmd.emit)
        begin
            if (last_reg)
            begin
                slot_cnt_next = '0;
                pad_idx_next  = slot_cnt_reg + CW'(1);
            end
            else
            begin
                slot_cnt_next = slot_cnt_reg + CW'(1);
            end
        end
        else if (cmd.pad)
        begin
            pad_idx_next = pad_idx_reg + CW'(1);
        end
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign out_idx   = cmd.emit ? slot_cnt_reg : pad_idx_reg;
    assign out_flags = cmd.emit ? encode_flags(data_reg, mask_reg, hit_reg) : 32'(pad_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_len_reg   <= '0;
            last_reg       <= 1'b0;
            scan_idx_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            slot_cnt_reg   <= '0;
            pad_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                scan_len_reg <= cfg_wdata;
            if (cmd.latch)
                last_reg <= s_tlast;
            scan_idx_reg <= scan_idx_next;
            rd_pend_reg  <= rd_pend_next;
            if (cmd.latch)
                hit_reg <= 1'b0;
            else if (match_now)
                hit_reg <= 1'b1;
            slot_cnt_reg <= slot_cnt_next;
            pad_idx_reg  <= pad_idx_next;
            if (cmd.emit || cmd.pad)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            data_reg <= in_data;
        if (match_now)
            mask_reg <= ram_rdata;
        if (cmd.emit || cmd.pad)
        begin
            out_index_reg <= IDX_W'(out_idx);
            out_word_reg  <= {out_flags, ENTRY_BASE + 32'(out_idx)};
            out_last_reg  <= (out_idx == CW'(OUT_ENTRIES - 1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_word_reg, out_index_reg};
    assign m_tlast  = out_last_reg;

    assign status.in_op       = opcode_t'(s_tuser);
    assign status.in_last     = s_tlast;
    assign status.slot_full   = (slot_cnt_reg >= CW'(OUT_ENTRIES));
    assign status.search_done = hit_reg || ((scan_idx_reg >= limit) && !rd_pend_reg);
    assign status.item_last   = last_reg;
    assign status.tail_full   = (slot_cnt_reg == CW'(OUT_ENTRIES - 1));
    assign status.out_free    = out_free;
    assign status.pad_end     = (pad_idx_reg == CW'(OUT_ENTRIES - 1));

endmodule

// ===== rtl/register_entry_flag_encoder_unit.sv =====
// Mask load, first-match search over the mask table and flag encoding, one item at a time.
// Mask loads, spare opcodes and entries past the last slot never leave idle. A source entry
// scans one mask per cycle behind the RAM read latency over min(scan length, MASK_DEPTH)
// entries, stopping at the first match on data[7:0]; its word is registered once the output
// is free, then the next item is taken. Padding adds one word per cycle while output is free.
// rst_n clears the slot counter, scan length and handshake state; the mask table is not cleared.
module register_entry_flag_encoder_unit #(
    parameter int MASK_DEPTH  = 16,
    parameter int OUT_ENTRIES = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [refe_pkg::CNT_W-1:0] cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [39:0]                s_tdata,   // slot[3:0], data[35:4]
    input  logic [1:0]                 s_tuser,   // opcode[1:0]
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [71:0]                m_tdata,   // entry_index[4:0], entry_word[68:5]
    output logic                       m_tlast
);
    import refe_pkg::*;

    refe_cmd_t    cmd;
    refe_status_t status;

    refe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    refe_dp #(
        .MASK_DEPTH  (MASK_DEPTH),
        .OUT_ENTRIES (OUT_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== tb/sv/refe_desc_checker.sv =====
// Checker for the register entry flag encoder: predicts descriptor words and compares them.
module refe_desc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // slot[3:0], data[35:4]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // entry_index[4:0], entry_word[68:5]
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    import refe_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int LIST_SLOTS  = 32;

    typedef struct {
        logic [4:0]  idx;
        logic [63:0] word;
        logic        is_last;
    } desc_t;

    desc_t       desc_queue[$];
    logic [31:0] mask_mem [TABLE_DEPTH];
    logic [4:0]  search_len;
    int          next_slot;

    function automatic logic [31:0] desc_flags(logic [31:0] s, logic [31:0] m, logic hit);
        logic [31:0] f;
        logic [31:0] mk;
        begin
            f  = '0;
            mk = m & s;
            if (s[21:20] == 2'd0)
            begin
                f[5]   = s[24] | ~hit;
                f[9:8] = s[29:28];
            end
            else
            begin
                f[25:24] = s[21:20];
                f[19]    = 1'b1;
                if (s[21:20] == 2'd2)
                begin
                    f[5]   = hit ? ~mk[21] : 1'b1;
                    f[9:8] = s[31:30];
                end
                else if (hit)
                begin
                    f[5]   = ~mk[20];
                    f[20]  = ~mk[21];
                    f[9:8] = s[31:30];
                end
                else
                begin
                    f[5]   = 1'b1;
                    f[20]  = 1'b1;
                    f[9:8] = s[29:28];
                end
                f[22:21] = s[31:30];
            end
            if (hit)
            begin
                f[4:0] = m[12:8];
                f[10]  = s[22] | s[24];
            end
            else
            begin
                f[4:0] = 5'd0;
                f[10]  = 1'b0;
            end
            return f;
        end
    endfunction

    function automatic void push_desc(int idx, logic [31:0] flags);
        desc_t d;
        begin
            d.idx     = idx[4:0];
            d.word    = {flags, ENTRY_BASE + 32'(idx)};
            d.is_last = (idx == LIST_SLOTS - 1);
            desc_queue.push_back(d);
        end
    endfunction

    function automatic void push_padding(int first);
        begin
            for (int i = first; i < LIST_SLOTS; i++)
                push_desc(i, 32'(i));
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        desc_t       want;
        logic [31:0] src;
        logic [31:0] found;
        logic        hit;
        if (!rst_n)
        begin
            desc_queue.delete();
            next_slot  = 0;
            search_len = 5'd0;
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (desc_queue.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none actual %h last %b",
                             $time, m_tdata[68:5], m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = desc_queue.pop_front();
                    if (m_tdata[4:0] !== want.idx || m_tdata[68:5] !== want.word ||
                        m_tlast !== want.is_last)
                    begin
                        $display("%0t: mismatch, expected idx %0d word %h last %b",
                                 $time, want.idx, want.word, want.is_last);
                        $display("%0t:           actual   idx %0d word %h last %b",
                                 $time, m_tdata[4:0], m_tdata[68:5], m_tlast);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
                search_len = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                src = s_tdata[35:4];
                if (s_tuser == OP_LOAD)
                    mask_mem[s_tdata[3:0]] = src;
                else if (s_tuser == OP_EMPTY)
                begin
                    next_slot = 0;
                    push_padding(0);
                end
                else if (s_tuser == OP_ENTRY)
                begin
                    if (next_slot < LIST_SLOTS)
                    begin
                        hit   = 1'b0;
                        found = '0;
                        for (int j = 0; j < TABLE_DEPTH; j++)
                        begin
                            if (!hit && j < search_len && mask_mem[j][7:0] == src[7:0])
                            begin
                                hit   = 1'b1;
                                found = mask_mem[j];
                            end
                        end
                        push_desc(next_slot, desc_flags(src, found, hit));
                        next_slot++;
                        if (s_tlast)
                            push_padding(next_slot);
                    end
                    if (s_tlast)
                        next_slot = 0;
                end
            end
            pending = desc_queue.size();
        end
    end

endmodule

// ===== tb/sv/tb_register_entry_flag_encoder_unit.sv =====
// Testbench top for the register entry flag encoder: reset, configuration, item stimulus, verdict.
module tb_register_entry_flag_encoder_unit;
    import refe_pkg::*;

    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam int         PHASES      = 8;
    localparam int         PHASE_ITEMS = 48;
    localparam int         SETTLE      = 30;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [4:0]  cfg_wdata = 5'd0;
    logic        s_tvalid  = 1'b0;
    logic [39:0] s_tdata   = '0;   // slot[3:0], data[35:4]
    logic [1:0]  s_tuser   = 2'd0; // opcode[1:0]
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [71:0] m_tdata;          // entry_index[4:0], entry_word[68:5]
    wire         m_tlast;

    logic        calm = 1'b0;
    int          fail_count;
    int          pending;
    int          item_count = 0;
    logic [31:0] mask_shadow [16];

    register_entry_flag_encoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    refe_desc_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic send_item(logic [1:0] op, logic [3:0] slot_no, logic [31:0] word,
                             logic is_last);
        begin
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= op;
            s_tdata  <= {4'd0, word, slot_no};
            s_tlast  <= is_last;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            if (op != OP_SPARE)
                item_count++;
        end
    endtask

    task automatic load_mask(logic [3:0] slot_no, logic [31:0] word);
        begin
            send_item(OP_LOAD, slot_no, word, 1'($urandom));
            mask_shadow[slot_no] = word;
        end
    endtask

    task automatic settle();
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
        end
    endtask

    task automatic set_scan_len(logic [4:0] count);
        begin
            settle();
            cfg_we    <= 1'b1;
            cfg_wdata <= count;
            @(posedge clk);
            cfg_we    <= 1'b0;
        end
    endtask

    function automatic logic [31:0] pick_entry();
        logic [31:0] word;
        begin
            word = $urandom;
            if ($urandom_range(0, 3) != 0)
                word[7:0] = mask_shadow[$urandom_range(0, 15)][7:0];
            return word;
        end
    endfunction

    // hold m_tready low in random bursts
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        #40_000_000;
        $display("FAIL register_entry_flag_encoder_unit");
        $finish;
    end

    initial
    begin
        int          phase_no;
        int          budget;
        int          n;
        int          pick;
        logic [31:0] word;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // scan length is zero here: entries search nothing
        send_item(OP_ENTRY, 4'h0, 32'h0000_0000, 1'b0);
        send_item(OP_ENTRY, 4'hF, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_SPARE, 4'hF, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_EMPTY, 4'h0, 32'h0000_0000, 1'b0);
        send_item(OP_ENTRY, 4'h5, 32'h0010_0000, 1'b0);
        send_item(OP_EMPTY, 4'hA, 32'h5A5A_5A5A, 1'b1);
        send_item(OP_ENTRY, 4'h3, 32'h5020_0000, 1'b1);

        // fill the table; slot 5 repeats the key of slot 4
        for (int k = 0; k < 16; k++)
        begin
            word = $urandom;
            if (k == 0)
                word[7:0] = 8'h00;
            else if (k == 15)
                word[7:0] = 8'hFF;
            else if (k == 5)
                word[7:0] = mask_shadow[4][7:0];
            load_mask(4'(k), word);
        end

        set_scan_len(5'd16);
        for (int k = 0; k < 4; k++)
        begin
            word        = $urandom;
            word[21:20] = 2'(k);
            word[7:0]   = mask_shadow[(k == 0) ? 0 : (k == 1) ? 15 : (k == 2) ? 5 : 9][7:0];
            send_item(OP_ENTRY, 4'(k), word, k == 3);
        end

        for (phase_no = 0; phase_no < PHASES; phase_no++)
        begin
            unique case (phase_no)
                0:       n = 1;
                1:       n = 15;
                2:       n = 0;
                3:       n = 16;
                4:       n = 8;
                5:       n = 2;
                6:       n = $urandom_range(0, 16);
                default: n = 16;
            endcase
            set_scan_len(5'(n));
            calm   = (phase_no == PHASES - 1);
            budget = item_count + PHASE_ITEMS;
            while (item_count < budget)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36)
                                                     : $urandom_range(1, 8);
                    for (int k = 0; k < n; k++)
                        send_item(OP_ENTRY, 4'($urandom), pick_entry(), k == n - 1);
                end
                else if (pick < 78)
                begin
                    word = $urandom;
                    if ($urandom_range(0, 1) != 0)
                        word[7:0] = mask_shadow[$urandom_range(0, 15)][7:0];
                    load_mask(4'($urandom), word);
                end
                else if (pick < 86)
                    send_item(OP_EMPTY, 4'($urandom), $urandom, 1'($urandom));
                else if (pick < 92)
                    send_item(OP_SPARE, 4'($urandom), $urandom, 1'($urandom));
                else
                begin
                    // leave a list open; the next list or an empty list cuts it
                    n = $urandom_range(1, 4);
                    for (int k = 0; k < n; k++)
                        send_item(OP_ENTRY, 4'($urandom), pick_entry(), 1'b0);
                end
            end
        end

        settle();
        if (fail_count == 0)
            $display("PASS register_entry_flag_encoder_unit");
        else
            $display("FAIL register_entry_flag_encoder_unit");
        $finish;
    end

endmodule

// ===== register_entry_flag_encoder_unit.f =====
rtl/refe_pkg.sv
rtl/refe_ram.sv
rtl/refe_ctrl.sv
rtl/refe_dp.sv
rtl/register_entry_flag_encoder_unit.sv
tb/sv/refe_desc_checker.sv
tb/sv/tb_register_entry_flag_encoder_unit.sv
